/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent must hold on the next clock, skipped in reset
`define PMFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmfb assertion failed");

// same check, also evaluated while reset is high
`define PMFB_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pmfb assertion failed");

// same-cycle implication, skipped in reset
`define PMFB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmfb assertion failed");

`endif

/* hw/rtl/pmfb_pkg.sv */
// types and constants of the paged mono frame buffer
// no dependencies; used by the top level and the checker
package pmfb_pkg;

   localparam int BYTE_W = 8;

   // command codes
   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_GET   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_EMIT  = 2'd3;

   // controller command bytes that open a frame, and a one-bit mask
   localparam logic [7:0] TX_SET_X = 8'h80;
   localparam logic [7:0] TX_SET_Y = 8'h40;
   localparam logic [7:0] BIT_ONE  = 8'h01;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] pixel_x;
      logic [5:0] pixel_y;
      logic       pixel_black;
   } req_type;

   typedef struct packed {
      logic       pixel_value;
      logic       out_of_range;
      logic [7:0] tx_byte;
      logic       tx_is_data;
      logic       tx_last;
   } rsp_type;

endpackage

/* hw/rtl/pmfb_ram.sv */
// generic single-port ram with registered read
// no dependencies
module pmfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 504
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/paged_mono_framebuffer.sv */
// paged mono frame buffer: frame store in one ram plus command sequencer
// depends on pmfb_pkg and pmfb_ram
//
//   channel   ports                          word
//   request   req_valid req_ready req_data   pmfb_pkg::req_type
//   response  rsp_valid rsp_ready rsp_data   pmfb_pkg::rsp_type
//
// one word in flight; the ram's single port and registered read set the pace
// set pixel reads the byte, then writes it back; get and data emit read the
// store, then answer; command emit, clear and out-of-range words answer from
// idle; clear then sweeps the store, one byte a cycle: WIDTH * ceil(HEIGHT/8)
// bytes (504 at the defaults) with req_ready low; reset runs the same sweep
// a response that is not taken holds the block in idle until it is taken
module paged_mono_framebuffer #(
   parameter int DISPLAY_WIDTH  = 84,
   parameter int DISPLAY_HEIGHT = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pmfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pmfb_pkg::rsp_type rsp_data
);

   localparam int PageCount  = (DISPLAY_HEIGHT + 7) / 8;
   localparam int StoreBytes = DISPLAY_WIDTH * PageCount;
   localparam int SeqLength  = StoreBytes + 2;
   localparam int AW         = $clog2(StoreBytes);
   localparam int PW         = $clog2(SeqLength);
   localparam logic [AW-1:0] LastIdx = AW'(StoreBytes - 1);
   localparam logic [PW-1:0] SeqLast = PW'(SeqLength - 1);
   localparam logic [7:0]    XLimit  = 8'(DISPLAY_WIDTH);
   localparam logic [6:0]    YLimit  = 7'(DISPLAY_HEIGHT);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_GET,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [2:0]        bit_ff, bit_in;
   logic              black_ff, black_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pmfb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                        ram_we;
   logic [AW-1:0]               ram_addr;
   logic [pmfb_pkg::BYTE_W-1:0] ram_wdata;
   logic [pmfb_pkg::BYTE_W-1:0] ram_rdata;
   logic [pmfb_pkg::BYTE_W-1:0] bit_mask;

   logic          req_fire;
   logic          req_oor;
   logic [AW-1:0] page_base;
   logic [AW-1:0] req_index;
   logic [AW-1:0] tx_index;
   logic [PW-1:0] pos_next;

   // frame store
   pmfb_ram #(
      .WIDTH(pmfb_pkg::BYTE_W),
      .DEPTH(StoreBytes)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // handshake
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // pixel address: page row times width plus column
   assign req_oor   = ({1'b0, req_data.pixel_x} >= XLimit) ||
                      ({1'b0, req_data.pixel_y} >= YLimit);
   assign page_base = AW'(req_data.pixel_y[5:3]) * AW'(DISPLAY_WIDTH);
   assign req_index = page_base + AW'(req_data.pixel_x);

   // transmit sequence position
   assign tx_index = AW'(pos_ff - PW'(2));
   assign pos_next = (pos_ff == SeqLast) ? '0 : pos_ff + PW'(1);
   assign bit_mask = pmfb_pkg::BIT_ONE << bit_ff;

   // sequencer next state, ram control and response
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      black_in     = black_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_addr     = req_index;
      ram_wdata    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            if (clr_ff == LastIdx) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               idx_in   = req_index;
               bit_in   = req_data.pixel_y[2:0];
               black_in = req_data.pixel_black;
               unique case (req_data.command)
                  pmfb_pkg::CMD_SET, pmfb_pkg::CMD_GET: begin
                     if (req_oor) begin
                        rsp_valid_in             = 1'b1;
                        rsp_data_in              = '0;
                        rsp_data_in.out_of_range = 1'b1;
                     end else if (req_data.command == pmfb_pkg::CMD_SET) begin
                        state_in = ST_RMW;
                     end else begin
                        state_in = ST_GET;
                     end
                  end
                  pmfb_pkg::CMD_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     clr_in       = '0;
                     state_in     = ST_CLEAR;
                  end
                  pmfb_pkg::CMD_EMIT: begin
                     pos_in = pos_next;
                     if (pos_ff == PW'(0)) begin
                        rsp_valid_in        = 1'b1;
                        rsp_data_in         = '0;
                        rsp_data_in.tx_byte = pmfb_pkg::TX_SET_X;
                     end else if (pos_ff == PW'(1)) begin
                        rsp_valid_in        = 1'b1;
                        rsp_data_in         = '0;
                        rsp_data_in.tx_byte = pmfb_pkg::TX_SET_Y;
                     end else begin
                        ram_addr = tx_index;
                        last_in  = (pos_ff == SeqLast);
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RMW: begin
            // write back the byte read last cycle with one bit changed
            ram_we       = 1'b1;
            ram_addr     = idx_ff;
            ram_wdata    = black_ff ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            state_in     = ST_IDLE;
         end
         ST_GET: begin
            rsp_valid_in            = 1'b1;
            rsp_data_in             = '0;
            rsp_data_in.pixel_value = ram_rdata[bit_ff];
            state_in                = ST_IDLE;
         end
         ST_EMIT: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in            = '0;
            rsp_data_in.tx_byte    = ram_rdata;
            rsp_data_in.tx_is_data = 1'b1;
            rsp_data_in.tx_last    = last_ff;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      bit_ff      <= bit_in;
      black_ff    <= black_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hw/rtl/pmfb_checker.sv */
// port-level checks of the paged mono frame buffer, bound to the top level
// depends on pmfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module pmfb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pmfb_pkg::rsp_type rsp_data
);

   // the request side is closed once reset has been sampled high
   `PMFB_ASSERT_NEXT_NR(a_reset_sweep, clock, reset, !req_ready)

   // a stalled response word holds
   `PMFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_data))

   // one word in flight: after an accept either its answer is out or input waits
   `PMFB_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready,
                     rsp_valid || !req_ready)

   // no response word appears without a request that caused it
   `PMFB_ASSERT_IMPL(a_rsp_cause, clock, reset, $rose(rsp_valid),
                     $past(req_valid && req_ready) || !$past(req_ready))

endmodule

bind paged_mono_framebuffer pmfb_checker u_pmfb_checker (.*);
